// ===== hw/rtl/cst_pkg.sv =====
// Shared types and constants for the call stack tracker.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`default_nettype none

package cst_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned CFG_W       = 7;
  localparam logic [CFG_W-1:0] MAX_CHAIN_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_BRANCH = 2'd0,
    OP_CALL   = 2'd1,
    OP_RETURN = 2'd2,
    OP_SAMPLE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RET_SCAN,
    ST_RET_POP,
    ST_SAMPLE
  } state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [ADDR_W-1:0] from_addr;
    logic [ADDR_W-1:0] to_addr;
    logic [LEN_W-1:0]  insn_length;
    logic [ADDR_W-1:0] trace_number;
    logic [ADDR_W-1:0] sample_ip;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] chain_addr;
    logic              chain_last;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the stack.
  typedef struct packed {
    logic push;       // shift entries one place away from the top
    logic pop;        // shift entries one place towards the top
    logic clr;        // drop valid bits (also of entries a push shifts down, but not of the new top)
    logic shd_load;   // copy entries into the readout chain
    logic shd_shift;  // advance the readout chain towards the top
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cst_cell.sv =====
// One stack cell: a return address, its valid bit and a readout copy.
// Depends on cst_pkg; instantiated in a row by call_stack_tracker.
`default_nettype none

module cst_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cst_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [cst_pkg::ADDR_W-1:0] up_data_i,
  input  wire logic                      up_valid_i,
  input  wire logic [cst_pkg::ADDR_W-1:0] dn_data_i,
  input  wire logic                      dn_valid_i,
  input  wire logic [cst_pkg::ADDR_W-1:0] dn_shadow_i,
  input  wire logic [cst_pkg::ADDR_W-1:0] match_addr_i,
  output logic [cst_pkg::ADDR_W-1:0]      data_o,
  output logic                            valid_o,
  output logic [cst_pkg::ADDR_W-1:0]      shadow_o,
  output logic                            hit_o
);

  logic [cst_pkg::ADDR_W-1:0] data_q, data_d;
  logic [cst_pkg::ADDR_W-1:0] shadow_q, shadow_d;
  logic                       valid_q, valid_d;

  always_comb begin
    data_d   = data_q;
    valid_d  = valid_q;
    shadow_d = shadow_q;
    if (ctrl_i.push) begin
      data_d  = up_data_i;
      valid_d = up_valid_i;
    end else if (ctrl_i.pop) begin
      data_d  = dn_data_i;
      valid_d = dn_valid_i;
    end else if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.shd_load) begin
      shadow_d = data_q;
    end else if (ctrl_i.shd_shift) begin
      shadow_d = dn_shadow_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    shadow_q <= shadow_d;
  end

  assign data_o   = data_q;
  assign valid_o  = valid_q;
  assign shadow_o = shadow_q;
  assign hit_o    = valid_q && (data_q == match_addr_i);

endmodule

`default_nettype wire

// ===== hw/rtl/call_stack_tracker.sv =====
// Call stack tracker: top level with control and the row of stack cells.
// Depends on cst_pkg and cst_cell.
//
// Rebuilds a return-address stack from branch items and reads it out on
// sample items. The stack is a row of StackDepth cells with the top always
// in the first cell, so a push or a one-entry pop is a single shift of the
// row. Branch and call items finish at acceptance, and so does a return
// from address zero or on an empty stack. For any other return item all
// cells compare against the target at once, then the row shifts up one
// entry a cycle until the matching entry has left; with no match the
// stack stays as it is. A sample item gives min(max_chain_length,
// depth+1) results (a zero setting counts as one), one per cycle while the
// output is not stalled, the sample address first and then the stack from
// the top; it is copied into a readout chain in the cells at acceptance.
// No new item is taken while a return or a sample is still in progress.
// The stack needs no clearing after reset.
`default_nettype none

module call_stack_tracker #(
  parameter int unsigned StackDepth = cst_pkg::STACK_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire cst_pkg::in_item_t        in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output cst_pkg::out_item_t            out_item_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [cst_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned NW   = (CntW + 1 > cst_pkg::CFG_W) ? CntW + 1 : cst_pkg::CFG_W;
  localparam int unsigned AW   = cst_pkg::ADDR_W;

  cst_pkg::state_e      state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [AW-1:0]        trace_q, trace_d;
  logic                 seen_q, seen_d;
  logic [cst_pkg::CFG_W-1:0] max_len_q;
  logic [NW-1:0]        rem_q, rem_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 out_valid_q, out_valid_d;
  cst_pkg::out_item_t   out_q, out_d;

  cst_pkg::cell_ctrl_t  ctrl;
  logic [AW-1:0]        push_data;
  logic                 push_ok;

  logic [AW-1:0] cell_data   [StackDepth];
  logic [AW-1:0] cell_shadow [StackDepth];
  logic [StackDepth-1:0] cell_valid;
  logic [StackDepth-1:0] cell_hit;

  logic           in_acc;
  logic           out_take;
  logic           trace_clr;
  logic [CntW-1:0] cnt_eff;
  logic [NW-1:0]  lim;
  logic [NW-1:0]  depth1;
  logic [NW-1:0]  n_res;

  // Row of cells; the top of the stack lives in cell 0.
  for (genvar p = 0; p < StackDepth; p++) begin : g_cell
    logic [AW-1:0] up_data;
    logic          up_valid;
    logic [AW-1:0] dn_data;
    logic          dn_valid;
    logic [AW-1:0] dn_shadow;

    if (p == 0) begin : g_top
      assign up_data  = push_data;
      assign up_valid = 1'b1;
    end else begin : g_mid
      assign up_data  = cell_data[p-1];
      assign up_valid = cell_valid[p-1] & ~ctrl.clr;
    end

    if (p == StackDepth - 1) begin : g_bot
      assign dn_data   = '0;
      assign dn_valid  = 1'b0;
      assign dn_shadow = '0;
    end else begin : g_inner
      assign dn_data   = cell_data[p+1];
      assign dn_valid  = cell_valid[p+1];
      assign dn_shadow = cell_shadow[p+1];
    end

    cst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .up_data_i    (up_data),
      .up_valid_i   (up_valid),
      .dn_data_i    (dn_data),
      .dn_valid_i   (dn_valid),
      .dn_shadow_i  (dn_shadow),
      .match_addr_i (addr_q),
      .data_o       (cell_data[p]),
      .valid_o      (cell_valid[p]),
      .shadow_o     (cell_shadow[p]),
      .hit_o        (cell_hit[p])
    );
  end

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != cst_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign push_data = in_item_i.from_addr + AW'(in_item_i.insn_length);
  assign push_ok   = (in_item_i.to_addr != '0) && (push_data != in_item_i.to_addr);
  assign trace_clr = seen_q && (in_item_i.trace_number != trace_q);
  assign cnt_eff   = trace_clr ? '0 : count_q;

  assign lim    = (max_len_q == '0) ? NW'(1) : NW'(max_len_q);
  assign depth1 = NW'(count_q) + NW'(1);
  assign n_res  = (lim < depth1) ? lim : depth1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    trace_d     = trace_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_take;
    ctrl        = '0;

    case (state_q)
      cst_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.opcode == cst_pkg::OP_SAMPLE) begin
            out_d.chain_addr = in_item_i.sample_ip;
            out_d.chain_last = (n_res == NW'(1));
            out_valid_d      = 1'b1;
            ctrl.shd_load    = 1'b1;
            rem_d            = n_res - NW'(1);
            if (n_res != NW'(1)) begin
              state_d = cst_pkg::ST_SAMPLE;
            end
          end else begin
            seen_d   = 1'b1;
            trace_d  = in_item_i.trace_number;
            ctrl.clr = trace_clr;
            count_d  = cnt_eff;
            if (in_item_i.opcode == cst_pkg::OP_CALL && push_ok) begin
              ctrl.push = 1'b1;
              // a full stack restarts from empty before the push
              if (trace_clr || count_q == CntW'(StackDepth)) begin
                ctrl.clr = 1'b1;
                count_d  = CntW'(1);
              end else begin
                count_d  = count_q + CntW'(1);
              end
            end else if (in_item_i.opcode == cst_pkg::OP_RETURN &&
                         in_item_i.from_addr != '0 && cnt_eff != '0) begin
              addr_d  = in_item_i.to_addr;
              state_d = cst_pkg::ST_RET_SCAN;
            end
          end
        end
      end
      cst_pkg::ST_RET_SCAN: begin
        // no match anywhere leaves the stack as it is
        state_d = (|cell_hit) ? cst_pkg::ST_RET_POP : cst_pkg::ST_IDLE;
      end
      cst_pkg::ST_RET_POP: begin
        ctrl.pop = 1'b1;
        count_d  = count_q - CntW'(1);
        if (cell_hit[0]) begin
          state_d = cst_pkg::ST_IDLE;
        end
      end
      cst_pkg::ST_SAMPLE: begin
        if (out_take) begin
          out_d.chain_addr = cell_shadow[0];
          out_d.chain_last = (rem_q == NW'(1));
          out_valid_d      = 1'b1;
          ctrl.shd_shift   = 1'b1;
          rem_d            = rem_q - NW'(1);
          if (rem_q == NW'(1)) begin
            state_d = cst_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cst_pkg::ST_IDLE;
      count_q     <= '0;
      trace_q     <= '0;
      seen_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      max_len_q   <= cst_pkg::MAX_CHAIN_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      trace_q     <= trace_d;
      seen_q      <= seen_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== bench/tb_call_stack_tracker.sv =====
// Self-checking bench for call_stack_tracker: a directed table, then random branch traces.
// Depends on cst_pkg and the RTL top; compares each chain item against a local stack model or a table entry.
`default_nettype none

module tb_call_stack_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int SETTLE_CYCLES = STACK_DEPTH + 8;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // local copy of the stack and the chain limit
  logic [ADDR_W-1:0] ras [STACK_DEPTH];
  int                depth = 0;
  logic [ADDR_W-1:0] cur_trace = '0;
  bit                trace_valid = 1'b0;
  int                chain_limit = int'(MAX_CHAIN_RST);

  out_item_t chain_buf[$];
  out_item_t chain_q[$];
  dir_row_t  dir_rows[$];

  idle_e idle_mode = IDLE_NONE;
  bit    hold_req = 1'b0;
  int    errors = 0;
  int    n_items = 0;
  int    n_samples = 0;
  int    n_checked = 0;
  int    n_wraps = 0;
  int    max_depth = 0;

  int    ph_cfg   [NUM_PHASES] = '{64, 1, 0, 127, 33, -1};
  idle_e ph_idle  [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                                   IDLE_BOTH};
  int    ph_calls [NUM_PHASES] = '{90, 50, 50, 70, 60, 55};
  int    ph_tchg  [NUM_PHASES] = '{0, 3, 3, 2, 3, 3};
  int    ph_len   [NUM_PHASES] = '{50, 35, 35, 40, 35, 35};
  bit    ph_hold  [NUM_PHASES] = '{0, 0, 0, 1, 0, 0};

  call_stack_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic int send_pct();
    return (idle_mode == IDLE_SEND) ? 57 : (idle_mode == IDLE_BOTH) ? 22 : 0;
  endfunction

  function automatic int recv_pct();
    return (idle_mode == IDLE_RECV) ? 57 : (idle_mode == IDLE_BOTH) ? 22 : 0;
  endfunction

  function automatic in_item_t mk(opcode_e op, logic [ADDR_W-1:0] from_a,
                                  logic [ADDR_W-1:0] to_a, logic [LEN_W-1:0] len,
                                  logic [ADDR_W-1:0] tnr, logic [ADDR_W-1:0] ip);
    in_item_t it;
    it.opcode       = op;
    it.from_addr    = from_a;
    it.to_addr      = to_a;
    it.insn_length  = len;
    it.trace_number = tnr;
    it.sample_ip    = ip;
    return it;
  endfunction

  // Update the local stack for one item; chain_buf receives any sample results.
  function automatic void track_item(input in_item_t it);
    logic [ADDR_W-1:0] ret;
    out_item_t         res;
    int                lim;
    int                n;
    int                k;
    bit                hit;
    chain_buf.delete();
    if (it.opcode == OP_SAMPLE) begin
      lim = (chain_limit == 0) ? 1 : chain_limit;
      n = (lim < depth + 1) ? lim : depth + 1;
      for (k = 0; k < n; k++) begin
        res.chain_addr = (k == 0) ? it.sample_ip : ras[depth - k];
        res.chain_last = (k == n - 1);
        chain_buf.push_back(res);
      end
      return;
    end
    if (!trace_valid) begin
      trace_valid = 1'b1;
      cur_trace = it.trace_number;
    end
    if (it.trace_number != cur_trace) begin
      cur_trace = it.trace_number;
      depth = 0;
    end
    if (it.opcode == OP_CALL) begin
      ret = it.from_addr + ADDR_W'(it.insn_length);
      if (it.to_addr != '0 && ret != it.to_addr) begin
        if (depth >= STACK_DEPTH) begin
          depth = 0;
          n_wraps++;
        end
        ras[depth] = ret;
        depth++;
      end
    end else if (it.opcode == OP_RETURN && it.from_addr != '0 && depth > 0) begin
      if (ras[depth - 1] == it.to_addr) begin
        depth--;
      end else begin
        hit = 1'b0;
        for (k = depth - 1; k > 0 && !hit; k--) begin
          if (ras[k - 1] == it.to_addr) begin
            depth = k - 1;
            hit = 1'b1;
          end
        end
      end
    end
    if (depth > max_depth) max_depth = depth;
  endfunction

  // Mostly plausible traffic: returns aim at stacked addresses, calls carry random content.
  function automatic in_item_t draw_item(int call_pct, int tchg_pct);
    in_item_t it;
    int       sel;
    int       pick;
    it = mk(OP_BRANCH, rnd64(), rnd64(), LEN_W'($urandom), rnd64(), rnd64());
    if (trace_valid) it.trace_number = cur_trace;
    if ($urandom_range(99) < tchg_pct) it.trace_number = rnd64();
    if ($urandom_range(99) < call_pct) begin
      it.opcode = OP_CALL;
      sel = $urandom_range(19);
      if (sel == 0) it.to_addr = '0;
      else if (sel == 1) it.to_addr = it.from_addr + ADDR_W'(it.insn_length);
      else if (sel < 8) it.insn_length = LEN_W'($urandom_range(1, 15));
    end else begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        it.opcode = OP_RETURN;
        if (depth > 0) begin
          pick = $urandom_range(9);
          if (pick < 6) it.to_addr = ras[depth - 1];
          else if (pick < 9) it.to_addr = ras[$urandom_range(depth - 1)];
        end
        if ($urandom_range(19) == 0) it.from_addr = '0;
      end else if (sel < 85) begin
        it.opcode = OP_SAMPLE;
      end
    end
    return it;
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    while (send_pct() > 0 && $urandom_range(99) < send_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    track_item(it);
    n_items++;
    if (it.opcode == OP_SAMPLE) n_samples++;
    if (typed) chain_q.push_back(want);
    else foreach (chain_buf[i]) chain_q.push_back(chain_buf[i]);
  endtask

  // Wait for outstanding chains, then give a return scan time to finish.
  task automatic settle_block();
    int waited;
    waited = 0;
    while (chain_q.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_chain_limit(input int value);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chain_limit = value;
  endtask

  // Receiver: random stalls per idle mode, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= (recv_pct() > 0 && $urandom_range(99) < recv_pct());
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (chain_q.size() == 0) begin
        $display("%0t: unexpected chain item addr %h last %b", $time,
                 out_item_o.chain_addr, out_item_o.chain_last);
        errors++;
      end else begin
        want = chain_q.pop_front();
        n_checked++;
        if (out_item_o.chain_addr !== want.chain_addr) begin
          $display("%0t: chain_addr expected %h, got %h", $time, want.chain_addr,
                   out_item_o.chain_addr);
          errors++;
        end
        if (out_item_o.chain_last !== want.chain_last) begin
          $display("%0t: chain_last expected %b, got %b", $time, want.chain_last,
                   out_item_o.chain_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d chain items outstanding", chain_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] t1;
    in_item_t          it;
    int                p;
    int                k;
    int                v;
    t1 = 64'h0123_4567_89ab_cdef;

    // sample before any event, empty stack, calls to zero and to their own return address
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, '0, '1), 1'b1, {64'hffff_ffff_ffff_ffff, 1'b1}});
    dir_rows.push_back('{mk(OP_SAMPLE, '1, '1, '1, '1, '0), 1'b1, {64'h0, 1'b1}});
    dir_rows.push_back('{mk(OP_BRANCH, 64'h10, 64'h20, 16'h2, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, 64'h1000, 64'h1004, 16'h4, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, 64'h3000, '0, 16'h2, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, t1, 64'h55), 1'b1, {64'h55, 1'b1}});
    // return address wraps past the top of the address space
    dir_rows.push_back('{mk(OP_CALL, '1, 64'h1, 16'hffff, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, '0, '1, '0, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, 64'h1000, 64'h2000, 16'h5, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, 64'h2000, 64'h4000, 16'h3, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, t1, 64'haaaa), 1'b0, '0});
    // return from zero, no match, lower match, top match
    dir_rows.push_back('{mk(OP_RETURN, '0, 64'h2003, '0, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_RETURN, 64'h4010, 64'h5555, '0, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_RETURN, 64'h4010, 64'h1005, '0, t1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, t1, 64'hbbbb), 1'b0, '0});
    dir_rows.push_back('{mk(OP_RETURN, 64'h7, '0, '0, t1, '0), 1'b0, '0});
    // trace change empties the stack
    dir_rows.push_back('{mk(OP_BRANCH, '1, '1, '1, '1, '1), 1'b0, '0});
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, '1, 64'h1), 1'b1, {64'h1, 1'b1}});
    dir_rows.push_back('{mk(OP_RETURN, 64'h5, 64'hfffe, '0, '1, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_CALL, 64'h8000, 64'h9000, 16'h10, '0, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_RETURN, 64'h9004, 64'h8010, '0, '0, '0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_SAMPLE, '0, '0, '0, '0, '1), 1'b1, {64'hffff_ffff_ffff_ffff, 1'b1}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    in_valid_i <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      v = (ph_cfg[p] < 0) ? $urandom_range(1, 64) : ph_cfg[p];
      set_chain_limit(v);
      idle_mode = ph_idle[p];
      hold_req = ph_hold[p];
      for (k = 0; k < ph_len[p]; k++) begin
        it = draw_item(ph_calls[p], ph_tchg[p]);
        push_item(it, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    idle_mode = IDLE_NONE;
    settle_block();
    if (chain_q.size() != 0) begin
      $display("%0t: %0d chain items never arrived", $time, chain_q.size());
      errors++;
    end

    $display("Sent %0d items (%0d samples), checked %0d chain addresses", n_items, n_samples,
             n_checked);
    $display("Deepest stack %0d, %0d full-stack wraps, chain limits 64/1/0/127/33/random",
             max_depth, n_wraps);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
